[rtl/pwli_pkg.sv]
// Shared types and codes for the piecewise-linear table interpolation block.
// Holds item field types, operation and status codes, and the sequencer states.
// No dependencies.
package pwli_pkg;

    localparam int KEY_W     = 16;
    localparam int VAL_W     = 16;
    localparam int ENTRY_W   = KEY_W + VAL_W;
    localparam int DIV_STEPS = 32;

    typedef logic signed [KEY_W-1:0] key_t;
    typedef logic signed [VAL_W-1:0] val_t;
    typedef logic [1:0]              func_t;
    typedef logic [2:0]              status_t;

    localparam func_t FUNC_LOAD  = 2'd0;
    localparam func_t FUNC_QUERY = 2'd1;
    localparam func_t FUNC_CLEAR = 2'd2;

    localparam status_t STAT_OK       = 3'd0;
    localparam status_t STAT_INTERP   = 3'd1;
    localparam status_t STAT_EXTRAP   = 3'd2;
    localparam status_t STAT_SAT      = 3'd3;
    localparam status_t STAT_FEW      = 3'd4;
    localparam status_t STAT_FULL     = 3'd5;
    localparam status_t STAT_ZERO_SEG = 3'd6;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FETCH_LO,
        ST_FETCH_HI,
        ST_LOAD_HI,
        ST_MUL,
        ST_DIV,
        ST_SUM,
        ST_DONE
    } state_t;

endpackage

[rtl/pwli_ram.sv]
// Generic single-port RAM with a registered read port.
// Used for the breakpoint table. No dependencies.
module pwli_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

[rtl/piecewise_linear_table_interp_core.sv]
// Top level of the piecewise-linear table interpolation block.
// Depends on pwli_pkg and pwli_ram.
//
// Usage notes.
// The input channel (in_valid/in_ready) carries one item: func, key_in and
// value_in. A load item appends a (key, value) breakpoint, a clear item empties
// the table, and a query item returns the matched or interpolated value.
// The output channel (out_valid/out_ready) returns exactly one item with
// value_out and status for every input item, in order.
// The block works on one item at a time and raises in_ready only when idle.
// Load, clear and unused items, and a query on an empty table, pass through the
// done state and raise out_valid, and in_ready returns in that same cycle.
// A query scans the stored keys through the single table port, one key per
// cycle, and stops at the first exact match. An interpolated or extrapolated
// query then fetches the segment, multiplies, runs the bit-serial divider and
// forms and posts the result.
// Reset empties the table and clears any pending result. When the receiver
// stalls, the finished result waits in the output register and the block
// holds its next result until that one is taken.
module piecewise_linear_table_interp_core #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  pwli_pkg::func_t  func,
    input  pwli_pkg::key_t   key_in,
    input  pwli_pkg::val_t   value_in,
    output logic             out_valid,
    input  logic             out_ready,
    output pwli_pkg::val_t   value_out,
    output pwli_pkg::status_t status
);

    import pwli_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    state_t state_reg, state_next;

    logic [CW-1:0] count_reg;
    logic [CW-1:0] scan_idx_reg;
    logic [CW-1:0] chk_idx_reg;
    logic          chk_vld_reg;
    logic          seg_found_reg;
    logic [CW-1:0] seg_idx_reg;
    logic [4:0]    div_cnt_reg;
    logic          out_valid_reg;

    key_t          q_reg;
    key_t          k_lo_reg;
    val_t          v_lo_reg;
    logic [15:0]   dq_mag_reg;
    logic          dq_neg_reg;
    logic [15:0]   dv_mag_reg;
    logic          dv_neg_reg;
    logic [15:0]   den_mag_reg;
    logic          den_neg_reg;
    logic          neg_reg;
    logic [31:0]   div_quo_reg;
    logic [16:0]   div_rem_reg;
    status_t       span_stat_reg;
    val_t          res_val_reg;
    status_t       res_stat_reg;
    val_t          value_out_reg;
    status_t       status_out_reg;

    logic                ram_we;
    logic [AW-1:0]       ram_addr;
    logic [ENTRY_W-1:0]  ram_wdata;
    logic [ENTRY_W-1:0]  ram_rdata;

    pwli_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    key_t          rd_key;
    val_t          rd_val;
    logic          in_fire;
    logic          table_full;
    logic [CW-1:0] last_idx;
    logic          chk_last;
    logic          key_match;
    logic          seg_hit;
    logic [CW-1:0] seg_sel;
    logic [CW-1:0] hi_idx;
    logic [CW-1:0] lo_idx;
    logic          out_free;

    logic signed [16:0] dq_full;
    logic signed [16:0] dq_inv;
    logic signed [16:0] dv_full;
    logic signed [16:0] dv_inv;
    logic signed [16:0] den_full;
    logic signed [16:0] den_inv;
    logic               den_zero;
    logic               q_above;
    logic               q_below;

    logic [16:0]        rem_sh;
    logic [17:0]        rem_diff;
    logic               rem_ge;
    logic signed [33:0] quot_s;
    logic signed [33:0] res_full;

    assign rd_key     = key_t'(ram_rdata[ENTRY_W-1:VAL_W]);
    assign rd_val     = val_t'(ram_rdata[VAL_W-1:0]);
    assign in_fire    = in_valid && in_ready;
    assign table_full = (count_reg >= CW'(TABLE_DEPTH));
    assign last_idx   = count_reg - CW'(1);
    assign chk_last   = chk_vld_reg && (chk_idx_reg == last_idx);
    assign key_match  = chk_vld_reg && (rd_key == q_reg);
    assign seg_hit    = chk_vld_reg && !seg_found_reg && (chk_idx_reg != last_idx)
                        && !(q_reg > rd_key);
    assign seg_sel    = seg_found_reg ? seg_idx_reg : last_idx;
    assign hi_idx     = (seg_sel == '0) ? CW'(1) : seg_sel;
    assign lo_idx     = hi_idx - CW'(1);
    assign out_free   = !out_valid_reg || out_ready;

    assign dq_full  = {q_reg[15], q_reg} - {rd_key[15], rd_key};
    assign dq_inv   = -dq_full;
    assign dv_full  = {rd_val[15], rd_val} - {v_lo_reg[15], v_lo_reg};
    assign dv_inv   = -dv_full;
    assign den_full = {rd_key[15], rd_key} - {k_lo_reg[15], k_lo_reg};
    assign den_inv  = -den_full;
    assign den_zero = (den_full == '0);
    assign q_above  = (q_reg > k_lo_reg) && (q_reg > rd_key);
    assign q_below  = (q_reg < k_lo_reg) && (q_reg < rd_key);

    assign rem_sh   = {div_rem_reg[15:0], div_quo_reg[31]};
    assign rem_diff = {1'b0, rem_sh} - {2'b00, den_mag_reg};
    assign rem_ge   = !rem_diff[17];
    assign quot_s   = neg_reg ? -{2'b00, div_quo_reg} : {2'b00, div_quo_reg};
    assign res_full = {{18{v_lo_reg[15]}}, v_lo_reg} + quot_s;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (func == FUNC_QUERY && count_reg != '0)
                    begin
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_SCAN:
            begin
                if (key_match)
                begin
                    state_next = ST_DONE;
                end
                else if (chk_last)
                begin
                    state_next = (count_reg < CW'(2)) ? ST_DONE : ST_FETCH_LO;
                end
            end
            ST_FETCH_LO: state_next = ST_FETCH_HI;
            ST_FETCH_HI: state_next = ST_LOAD_HI;
            ST_LOAD_HI:  state_next = den_zero ? ST_DONE : ST_MUL;
            ST_MUL:      state_next = ST_DIV;
            ST_DIV:
            begin
                if (div_cnt_reg == 5'(DIV_STEPS - 1))
                begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM:      state_next = ST_DONE;
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready  = 1'b0;
        ram_we    = 1'b0;
        ram_addr  = scan_idx_reg[AW-1:0];
        ram_wdata = {key_in, value_in};
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                ram_addr = count_reg[AW-1:0];
                ram_we   = in_valid && (func == FUNC_LOAD) && !table_full;
            end
            ST_FETCH_LO: ram_addr = lo_idx[AW-1:0];
            ST_FETCH_HI: ram_addr = hi_idx[AW-1:0];
            default:     ram_addr = scan_idx_reg[AW-1:0];
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            scan_idx_reg  <= '0;
            chk_idx_reg   <= '0;
            chk_vld_reg   <= 1'b0;
            seg_found_reg <= 1'b0;
            seg_idx_reg   <= '0;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    scan_idx_reg  <= '0;
                    chk_vld_reg   <= 1'b0;
                    seg_found_reg <= 1'b0;
                    if (in_fire && func == FUNC_LOAD && !table_full)
                    begin
                        count_reg <= count_reg + CW'(1);
                    end
                    if (in_fire && func == FUNC_CLEAR)
                    begin
                        count_reg <= '0;
                    end
                end
                ST_SCAN:
                begin
                    chk_vld_reg <= (scan_idx_reg < count_reg);
                    chk_idx_reg <= scan_idx_reg;
                    if (scan_idx_reg < count_reg)
                    begin
                        scan_idx_reg <= scan_idx_reg + CW'(1);
                    end
                    if (seg_hit)
                    begin
                        seg_found_reg <= 1'b1;
                        seg_idx_reg   <= chk_idx_reg;
                    end
                end
                ST_MUL:  div_cnt_reg <= '0;
                ST_DIV:  div_cnt_reg <= div_cnt_reg + 5'd1;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                q_reg        <= key_in;
                res_val_reg  <= '0;
                if (func == FUNC_LOAD && table_full)
                begin
                    res_stat_reg <= STAT_FULL;
                end
                else if (func == FUNC_QUERY && count_reg == '0)
                begin
                    res_stat_reg <= STAT_FEW;
                end
                else
                begin
                    res_stat_reg <= STAT_OK;
                end
            end
            ST_SCAN:
            begin
                if (key_match)
                begin
                    res_val_reg  <= rd_val;
                    res_stat_reg <= STAT_OK;
                end
                else if (chk_last)
                begin
                    res_val_reg  <= '0;
                    res_stat_reg <= STAT_FEW;
                end
            end
            ST_FETCH_HI:
            begin
                k_lo_reg   <= rd_key;
                v_lo_reg   <= rd_val;
                dq_neg_reg <= dq_full[16];
                dq_mag_reg <= dq_full[16] ? dq_inv[15:0] : dq_full[15:0];
            end
            ST_LOAD_HI:
            begin
                dv_neg_reg    <= dv_full[16];
                dv_mag_reg    <= dv_full[16] ? dv_inv[15:0] : dv_full[15:0];
                den_neg_reg   <= den_full[16];
                den_mag_reg   <= den_full[16] ? den_inv[15:0] : den_full[15:0];
                span_stat_reg <= (q_above || q_below) ? STAT_EXTRAP : STAT_INTERP;
                res_val_reg   <= '0;
                res_stat_reg  <= STAT_ZERO_SEG;
            end
            ST_MUL:
            begin
                div_quo_reg <= dq_mag_reg * dv_mag_reg;
                div_rem_reg <= '0;
                neg_reg     <= dq_neg_reg ^ dv_neg_reg ^ den_neg_reg;
            end
            ST_DIV:
            begin
                div_rem_reg <= rem_ge ? rem_diff[16:0] : rem_sh;
                div_quo_reg <= {div_quo_reg[30:0], rem_ge};
            end
            ST_SUM:
            begin
                if (res_full > 34'sd32767)
                begin
                    res_val_reg  <= 16'sh7FFF;
                    res_stat_reg <= STAT_SAT;
                end
                else if (res_full < -34'sd32768)
                begin
                    res_val_reg  <= 16'sh8000;
                    res_stat_reg <= STAT_SAT;
                end
                else
                begin
                    res_val_reg  <= res_full[15:0];
                    res_stat_reg <= span_stat_reg;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    value_out_reg  <= res_val_reg;
                    status_out_reg <= res_stat_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign value_out = value_out_reg;
    assign status    = status_out_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(TABLE_DEPTH))
        else $error("Point count exceeds the table depth.");

    a_write_on_load: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (in_fire && func == FUNC_LOAD && !table_full))
        else $error("Table written outside an accepted load item.");

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && chk_vld_reg) |-> (chk_idx_reg < count_reg))
        else $error("Scan compared an entry beyond the stored points.");

    a_sum_after_div: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SUM) |-> ($past(state_reg) == ST_DIV))
        else $error("Result formed without a finished division.");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_DONE))
        else $error("Output item posted outside the done state.");

endmodule

[bench/testbench.sv]
// Self-checking bench for piecewise_linear_table_interp_core: breakpoint loads, clears and
// queries, each answer checked against a table and interpolation model or a fixed answer.
// Depends on pwli_pkg and the RTL of the block.
module testbench;
    import pwli_pkg::*;

    localparam int TABLE_DEPTH = 64;
    localparam int RANDOM_ITEMS = 650;
    localparam int CYCLE_LIMIT = 600000;
    localparam func_t FUNC_NOP = 2'd3;

    typedef struct packed {
        val_t    value;
        status_t status;
    } answer_t;

    typedef struct packed {
        func_t   f;
        key_t    k;
        val_t    v;
        logic    typed;
        val_t    ev;
        status_t es;
    } stim_row_t;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    in_valid = 1'b0;
    logic    in_ready;
    func_t   func = FUNC_LOAD;
    key_t    key_in = '0;
    val_t    value_in = '0;
    logic    out_valid;
    logic    out_ready = 1'b0;
    val_t    value_out;
    status_t status;

    key_t      curve_key [TABLE_DEPTH];
    val_t      curve_val [TABLE_DEPTH];
    int        curve_len = 0;
    answer_t   pending_answers[$];
    stim_row_t directed_rows[$];
    int        items_sent = 0;
    int        mismatches = 0;
    int        cycle_count = 0;
    bit        quiet = 1'b0;

    piecewise_linear_table_interp_core #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .func(func),
        .key_in(key_in),
        .value_in(value_in),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .value_out(value_out),
        .status(status)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic answer_t table_answer(func_t f, key_t k, val_t v);
        answer_t a;
        int      i;
        int      seg;
        bit      found;
        longint  q;
        longint  k_lo;
        longint  k_hi;
        longint  v_lo;
        longint  v_hi;
        longint  span;
        longint  interp;
        a.value = '0;
        a.status = STAT_OK;
        found = 1'b0;
        case (f)
            FUNC_LOAD:
            begin
                if (curve_len >= TABLE_DEPTH)
                begin
                    a.status = STAT_FULL;
                end
                else
                begin
                    curve_key[curve_len] = k;
                    curve_val[curve_len] = v;
                    curve_len++;
                end
            end
            FUNC_CLEAR:
            begin
                curve_len = 0;
            end
            FUNC_QUERY:
            begin
                q = k;
                for (i = 0; i < curve_len && !found; i++)
                begin
                    if (curve_key[i] == k)
                    begin
                        found = 1'b1;
                        a.value = curve_val[i];
                    end
                end
                if (!found && curve_len < 2)
                begin
                    a.status = STAT_FEW;
                end
                else if (!found)
                begin
                    seg = 0;
                    while (seg < curve_len - 1 && q > curve_key[seg])
                        seg++;
                    if (seg == 0)
                        seg = 1;
                    k_lo = curve_key[seg-1];
                    k_hi = curve_key[seg];
                    v_lo = curve_val[seg-1];
                    v_hi = curve_val[seg];
                    span = k_hi - k_lo;
                    if (span == 0)
                    begin
                        a.status = STAT_ZERO_SEG;
                    end
                    else
                    begin
                        interp = v_lo + (q - k_lo) * (v_hi - v_lo) / span;
                        if ((q > k_lo && q > k_hi) || (q < k_lo && q < k_hi))
                            a.status = STAT_EXTRAP;
                        else
                            a.status = STAT_INTERP;
                        if (interp > 32767)
                        begin
                            a.value = 16'h7FFF;
                            a.status = STAT_SAT;
                        end
                        else if (interp < -32768)
                        begin
                            a.value = 16'h8000;
                            a.status = STAT_SAT;
                        end
                        else
                        begin
                            a.value = val_t'(interp);
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
        return a;
    endfunction

    task automatic send_item(input func_t f, input key_t k, input val_t v, input bit typed,
                             input val_t ev, input status_t es);
        int      gap;
        answer_t a;
        gap = quiet ? 0 : $urandom_range(0, 12);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        func <= f;
        key_in <= k;
        value_in <= v;
        do @(posedge clk); while (!in_ready);
        a = table_answer(f, k, v);
        if (typed)
        begin
            a.value = ev;
            a.status = es;
        end
        pending_answers = {pending_answers, a};
        items_sent++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_answers.size() != 0)
            @(posedge clk);
    endtask

    task automatic play_curve();
        key_t kept[$];
        int   n;
        int   pick;
        int   step_max;
        int   kk;
        int   j;
        int   lo;
        int   hi;
        int   tmp;
        bit   small_vals;
        key_t qk;
        val_t vv;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            n = $urandom_range(60, 66);
        else if (pick == 1)
            n = $urandom_range(0, 1);
        else
            n = $urandom_range(2, 12);
        small_vals = $urandom_range(0, 1);
        send_item(FUNC_CLEAR, key_t'($urandom), val_t'($urandom), 1'b0, '0, STAT_OK);
        step_max = 60000 / (n > 0 ? n : 1);
        kk = -32768 + int'($urandom_range(0, 2000));
        for (j = 0; j < n; j++)
        begin
            if (j > 0)
                kk += ($urandom_range(0, 15) == 0) ? 0 : int'($urandom_range(1, step_max));
            qk = ($urandom_range(0, 24) == 0) ? key_t'($urandom) : key_t'(kk);
            vv = small_vals ? val_t'(int'($urandom_range(0, 8192)) - 4096) : val_t'($urandom);
            kept = {kept, qk};
            send_item(FUNC_LOAD, qk, vv, 1'b0, '0, STAT_OK);
        end
        lo = 0;
        hi = 0;
        if (kept.size() > 0)
        begin
            lo = int'(kept[0]);
            hi = int'(kept[kept.size()-1]);
            if (hi < lo)
            begin
                tmp = lo;
                lo = hi;
                hi = tmp;
            end
        end
        repeat ($urandom_range(3, 10))
        begin
            pick = $urandom_range(0, 9);
            if (kept.size() > 0 && pick < 2)
                qk = kept[$urandom_range(0, kept.size() - 1)];
            else if (pick == 2)
                qk = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
            else if (pick == 3 || kept.size() == 0)
                qk = key_t'($urandom);
            else
                qk = key_t'(lo + int'($urandom_range(0, hi - lo)));
            send_item(FUNC_QUERY, qk, val_t'($urandom), 1'b0, '0, STAT_OK);
        end
    endtask

    task automatic play_noise();
        repeat ($urandom_range(4, 10))
            send_item(func_t'($urandom_range(0, 3)), key_t'($urandom), val_t'($urandom),
                      1'b0, '0, STAT_OK);
    endtask

    initial
    begin
        int      stall;
        answer_t a;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = quiet ? 0 : $urandom_range(0, 12);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            if (pending_answers.size() == 0)
            begin
                $display("%0t: unexpected item, value_out %0d status %0d",
                         $time, value_out, status);
                mismatches++;
            end
            else
            begin
                a = pending_answers.pop_front();
                if (value_out !== a.value)
                begin
                    $display("%0t: value_out expected %0d actual %0d", $time, a.value, value_out);
                    mismatches++;
                end
                if (status !== a.status)
                begin
                    $display("%0t: status expected %0d actual %0d", $time, a.status, status);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        int target;
        bit first;
        directed_rows = '{
            '{FUNC_QUERY, 16'h0000, 16'h0000, 1'b1, 16'h0000, STAT_FEW},
            '{FUNC_NOP,   16'hFFFF, 16'hFFFF, 1'b1, 16'h0000, STAT_OK},
            '{FUNC_LOAD,  16'h0100, 16'h1000, 1'b1, 16'h0000, STAT_OK},
            '{FUNC_QUERY, 16'h0100, 16'h0000, 1'b1, 16'h1000, STAT_OK},
            '{FUNC_QUERY, 16'h0200, 16'h0000, 1'b1, 16'h0000, STAT_FEW},
            '{FUNC_LOAD,  16'h0300, 16'h3000, 1'b1, 16'h0000, STAT_OK},
            '{FUNC_QUERY, 16'h0200, 16'h0000, 1'b0, 16'h0000, STAT_OK},
            '{FUNC_QUERY, 16'h8000, 16'h0000, 1'b0, 16'h0000, STAT_OK},
            '{FUNC_QUERY, 16'h7FFF, 16'h0000, 1'b0, 16'h0000, STAT_OK},
            '{FUNC_QUERY, 16'h0000, 16'h0000, 1'b0, 16'h0000, STAT_OK},
            '{FUNC_QUERY, 16'h0400, 16'h0000, 1'b0, 16'h0000, STAT_OK},
            '{FUNC_CLEAR, 16'hFFFF, 16'hFFFF, 1'b1, 16'h0000, STAT_OK},
            '{FUNC_QUERY, 16'h0100, 16'h0000, 1'b1, 16'h0000, STAT_FEW},
            '{FUNC_LOAD,  16'h8000, 16'h8000, 1'b1, 16'h0000, STAT_OK},
            '{FUNC_LOAD,  16'h7FFF, 16'h7FFF, 1'b1, 16'h0000, STAT_OK},
            '{FUNC_QUERY, 16'h8000, 16'h0000, 1'b1, 16'h8000, STAT_OK},
            '{FUNC_QUERY, 16'h7FFF, 16'h0000, 1'b1, 16'h7FFF, STAT_OK},
            '{FUNC_QUERY, 16'h0000, 16'h0000, 1'b0, 16'h0000, STAT_OK},
            '{FUNC_CLEAR, 16'h0000, 16'h0000, 1'b1, 16'h0000, STAT_OK},
            '{FUNC_LOAD,  16'h0100, 16'h0005, 1'b1, 16'h0000, STAT_OK},
            '{FUNC_LOAD,  16'h0100, 16'h0007, 1'b1, 16'h0000, STAT_OK},
            '{FUNC_QUERY, 16'h0200, 16'h0000, 1'b1, 16'h0000, STAT_ZERO_SEG},
            '{FUNC_QUERY, 16'h0100, 16'h0000, 1'b1, 16'h0005, STAT_OK},
            '{FUNC_LOAD,  16'h0050, 16'h7FFF, 1'b1, 16'h0000, STAT_OK},
            '{FUNC_QUERY, 16'h0080, 16'h0000, 1'b0, 16'h0000, STAT_OK},
            '{FUNC_QUERY, 16'h0200, 16'h0000, 1'b0, 16'h0000, STAT_OK}
        };
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (directed_rows[r])
            send_item(directed_rows[r].f, directed_rows[r].k, directed_rows[r].v,
                      directed_rows[r].typed, directed_rows[r].ev, directed_rows[r].es);
        target = items_sent + RANDOM_ITEMS;
        first = 1'b1;
        while (items_sent < target)
        begin
            quiet = ($urandom_range(0, 4) == 0);
            if (first || $urandom_range(0, 5) == 0)
                wait_drained();
            first = 1'b0;
            if ($urandom_range(0, 7) == 0)
                play_noise();
            else
                play_curve();
        end
        wait_drained();
        repeat (150) @(posedge clk);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
